@@ rtl/core/crtg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Climb-rate tone generator package
// Shared widths, register indexes, constants, divider handshake types and FSM states.
// ----------------------------------------------------------------------------
package crtg_pkg;

    localparam int RATE_W   = 12;
    localparam int ACC_W    = 20;
    localparam int TIME_W   = 32;
    localparam int TONE_W   = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int DIVD_W   = 38;
    localparam int DIVS_W   = 31;
    localparam int QUOT_W   = 16;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_CLIMB_THR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SINK_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FS_FREQ    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FS_RATE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CLIMB  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_W   = 3'd5;

    localparam logic [10:0] CLIMB_THR_RST = 11'd50;
    localparam logic [11:0] SINK_THR_RST  = 12'hF4C;
    localparam logic [12:0] FS_FREQ_RST   = 13'd1605;
    localparam logic [10:0] FS_RATE_RST   = 11'd390;
    localparam logic [12:0] MAX_CLIMB_RST = 13'd1000;
    localparam logic [8:0]  SMOOTH_W_RST  = 9'd38;

    localparam logic [8:0]        WEIGHT_ONE     = 9'd256;
    localparam logic [24:0]       PERIOD_SCALE   = 25'd25600000;
    localparam logic [TONE_W-1:0] FIXED_TONE_HZ  = 16'd400;
    localparam logic [TONE_W-1:0] FIXED_PERIOD   = 16'd1000;
    localparam logic [QUOT_W-1:0] QUOT_SAT       = 16'hFFFF;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [12:0] {
        ST_IDLE   = 13'b0000000000001,
        ST_KEEP   = 13'b0000000000010,
        ST_SMOOTH = 13'b0000000000100,
        ST_AVG    = 13'b0000000001000,
        ST_DECIDE = 13'b0000000010000,
        ST_MUL_F  = 13'b0000000100000,
        ST_DIV_F  = 13'b0000001000000,
        ST_WAIT_F = 13'b0000010000000,
        ST_MUL_D  = 13'b0000100000000,
        ST_MUL_N  = 13'b0001000000000,
        ST_DIV_P  = 13'b0010000000000,
        ST_WAIT_P = 13'b0100000000000,
        ST_OUT    = 13'b1000000000000
    } state_t;

endpackage
`default_nettype wire

@@ rtl/core/crtg_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Saturating restoring divider
// One quotient bit per cycle, 16-bit quotient saturated to all ones.
// ----------------------------------------------------------------------------
module crtg_div
    import crtg_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic                 busy_reg;
    logic                 done_reg;
    logic [3:0]           cnt_reg;
    logic [DIVD_W-1:0]    rem_reg;
    logic [DIVS_W+14:0]   dsh_reg;
    logic [QUOT_W-1:0]    quot_reg;
    logic                 sat;
    logic                 ge;

    assign sat = {{(DIVS_W+16-DIVD_W){1'b0}}, req.dividend} >= {req.divisor, 16'b0};
    assign ge  = {{(DIVS_W+15-DIVD_W){1'b0}}, rem_reg} >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= !sat;
            done_reg <= sat;
            cnt_reg  <= 4'd15;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 4'd1;
            if (cnt_reg == 4'd0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.dividend;
            dsh_reg  <= {req.divisor, 15'b0};
            quot_reg <= sat ? QUOT_SAT : '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - dsh_reg[DIVD_W-1:0];
            end
            quot_reg <= {quot_reg[QUOT_W-2:0], ge};
            dsh_reg  <= dsh_reg >> 1;
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule
`default_nettype wire

@@ rtl/core/climb_rate_tone_generator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Climb-rate tone generator
// Smooths and averages climb-rate samples and issues tone frequency/period.
// Flow: each input runs through KEEP, SMOOTH, AVG and DECIDE to OUT; with a
//   climb tone it also runs MUL_F, DIV_F, WAIT_F, MUL_D, MUL_N, DIV_P and
//   WAIT_P (two divider runs; a wait is cut short when its quotient saturates).
// Throughput: one item at a time; the next input is taken only after the
//   previous result is registered, and OUT holds while the output is stalled.
// Reset: rst_n asynchronous active low; clears accumulators, tone timer and
//   output valid, sets tone period to 1000 ms and registers to their defaults.
// ----------------------------------------------------------------------------
module climb_rate_tone_generator
    import crtg_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    // climb_rate[11:0], now_ms[43:12], tone_due[44], zero[47:45]
    input  wire logic [IN_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                    s_axis_tvalid,
    output logic                         s_axis_tready,
    // smoothed_rate[11:0], average_rate[23:12], tone_write[24], tone_hz[40:25],
    // period_ms[56:41], zero[63:57]
    output logic [OUT_TDATA_W-1:0]       m_axis_tdata,
    output logic                         m_axis_tvalid,
    input  wire logic                    m_axis_tready,
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]    cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]   cfg_data
);

    state_t                     state_reg;
    state_t                     state_next;

    logic [10:0]                climb_thr_reg;
    logic [11:0]                sink_thr_reg;
    logic [12:0]                fs_freq_reg;
    logic [10:0]                fs_rate_reg;
    logic [12:0]                max_climb_reg;
    logic [8:0]                 smooth_w_reg;

    logic signed [ACC_W-1:0]    smooth_acc_reg;
    logic signed [ACC_W-1:0]    avg_acc_reg;
    logic [TIME_W-1:0]          start_ms_reg;
    logic [TONE_W-1:0]          period_reg;

    logic signed [RATE_W-1:0]   rate_reg;
    logic [TIME_W-1:0]          now_reg;
    logic                       due_reg;
    logic signed [38:0]         prod_reg;
    logic [DIVS_W-1:0]          den_reg;
    logic [TONE_W-1:0]          hz_reg;
    logic                       wr_reg;

    logic                       out_valid_reg;
    logic [OUT_TDATA_W-1:0]     out_data_reg;

    logic [8:0]                 w_eff;
    logic [8:0]                 keep_w;
    logic [12:0]                mc_eff;
    logic signed [20:0]         mul_a;
    logic [24:0]                mul_b;
    logic signed [46:0]         prod;
    logic signed [28:0]         keep_sum;
    logic signed [28:0]         keep_sh;
    logic signed [20:0]         smooth_sum;
    logic signed [20:0]         avg_sum;
    logic [TIME_W-1:0]          elapsed;
    logic                       fire;
    logic                       above_climb;
    logic                       below_sink;
    logic                       out_free;
    div_req_t                   div_req;
    div_rsp_t                   div_rsp;

    assign cfg_ready     = 1'b1;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign w_eff  = (smooth_w_reg > WEIGHT_ONE) ? WEIGHT_ONE : smooth_w_reg;
    assign keep_w = WEIGHT_ONE - w_eff;
    assign mc_eff = (max_climb_reg == 13'd0) ? 13'd1 : max_climb_reg;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_KEEP:
            begin
                mul_a = {smooth_acc_reg[ACC_W-1], smooth_acc_reg};
                mul_b = {16'b0, keep_w};
            end
            ST_SMOOTH:
            begin
                mul_a = {{9{rate_reg[RATE_W-1]}}, rate_reg};
                mul_b = {16'b0, w_eff};
            end
            ST_MUL_F:
            begin
                mul_a = {avg_acc_reg[ACC_W-1], avg_acc_reg};
                mul_b = {12'b0, fs_freq_reg};
            end
            ST_MUL_D:
            begin
                mul_a = {avg_acc_reg[ACC_W-1], avg_acc_reg};
                mul_b = {14'b0, fs_rate_reg};
            end
            ST_MUL_N:
            begin
                mul_a = {8'b0, mc_eff};
                mul_b = PERIOD_SCALE;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod       = mul_a * $signed({1'b0, mul_b});
    assign keep_sum   = $signed(prod_reg[28:0]) + 29'sd128;
    assign keep_sh    = keep_sum >>> 8;
    assign smooth_sum = prod[20:0] + keep_sh[20:0];
    assign avg_sum    = {avg_acc_reg[ACC_W-1], avg_acc_reg}
                      + {smooth_acc_reg[ACC_W-1], smooth_acc_reg};

    assign elapsed     = now_reg - start_ms_reg;
    assign fire        = due_reg && (elapsed > {16'b0, period_reg});
    assign above_climb = $signed({avg_acc_reg[ACC_W-1], avg_acc_reg})
                       > $signed({2'b0, climb_thr_reg, 8'b0});
    assign below_sink  = avg_acc_reg < $signed({sink_thr_reg, 8'b0});

    always_comb
    begin
        div_req.start    = (state_reg == ST_DIV_F) || (state_reg == ST_DIV_P);
        div_req.dividend = {14'b0, prod_reg[31:8]};
        div_req.divisor  = {18'b0, mc_eff};
        if (state_reg == ST_DIV_P)
        begin
            div_req.dividend = prod_reg[DIVD_W-1:0];
            div_req.divisor  = den_reg;
        end
    end

    crtg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_axis_tvalid) state_next = ST_KEEP;
            ST_KEEP:   state_next = ST_SMOOTH;
            ST_SMOOTH: state_next = ST_AVG;
            ST_AVG:    state_next = ST_DECIDE;
            ST_DECIDE: state_next = (fire && above_climb) ? ST_MUL_F : ST_OUT;
            ST_MUL_F:  state_next = ST_DIV_F;
            ST_DIV_F:  state_next = ST_WAIT_F;
            ST_WAIT_F: if (div_rsp.done) state_next = ST_MUL_D;
            ST_MUL_D:  state_next = ST_MUL_N;
            ST_MUL_N:  state_next = ST_DIV_P;
            ST_DIV_P:  state_next = ST_WAIT_P;
            ST_WAIT_P: if (div_rsp.done) state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            climb_thr_reg <= CLIMB_THR_RST;
            sink_thr_reg  <= SINK_THR_RST;
            fs_freq_reg   <= FS_FREQ_RST;
            fs_rate_reg   <= FS_RATE_RST;
            max_climb_reg <= MAX_CLIMB_RST;
            smooth_w_reg  <= SMOOTH_W_RST;
            smooth_acc_reg <= '0;
            avg_acc_reg   <= '0;
            start_ms_reg  <= '0;
            period_reg    <= FIXED_PERIOD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                unique case (cfg_addr)
                    REG_CLIMB_THR: climb_thr_reg <= cfg_data[10:0];
                    REG_SINK_THR:  sink_thr_reg  <= cfg_data[11:0];
                    REG_FS_FREQ:   fs_freq_reg   <= cfg_data;
                    REG_FS_RATE:   fs_rate_reg   <= cfg_data[10:0];
                    REG_MAX_CLIMB: max_climb_reg <= cfg_data;
                    REG_SMOOTH_W:  smooth_w_reg  <= cfg_data[8:0];
                    default:       ;
                endcase
            end

            if (state_reg == ST_SMOOTH)
            begin
                smooth_acc_reg <= smooth_sum[ACC_W-1:0];
            end
            if (state_reg == ST_AVG)
            begin
                avg_acc_reg <= avg_sum[ACC_W:1];
            end
            if ((state_reg == ST_DECIDE) && fire)
            begin
                start_ms_reg <= now_reg;
                if (!above_climb && !below_sink)
                begin
                    period_reg <= FIXED_PERIOD;
                end
            end
            if ((state_reg == ST_WAIT_P) && div_rsp.done)
            begin
                period_reg <= div_rsp.quotient;
            end

            if ((state_reg == ST_OUT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            rate_reg <= s_axis_tdata[11:0];
            now_reg  <= s_axis_tdata[43:12];
            due_reg  <= s_axis_tdata[44];
            hz_reg   <= '0;
            wr_reg   <= 1'b0;
        end

        if ((state_reg == ST_KEEP) || (state_reg == ST_MUL_F)
            || (state_reg == ST_MUL_D) || (state_reg == ST_MUL_N))
        begin
            prod_reg <= prod[38:0];
        end
        if (state_reg == ST_MUL_N)
        begin
            den_reg <= prod_reg[DIVS_W-1:0];
        end

        if ((state_reg == ST_DECIDE) && fire && !above_climb && !below_sink)
        begin
            hz_reg <= FIXED_TONE_HZ;
            wr_reg <= 1'b1;
        end
        if ((state_reg == ST_WAIT_F) && div_rsp.done)
        begin
            hz_reg <= div_rsp.quotient;
        end
        if ((state_reg == ST_WAIT_P) && div_rsp.done)
        begin
            wr_reg <= 1'b1;
        end

        if ((state_reg == ST_OUT) && out_free)
        begin
            out_data_reg <= {7'b0, period_reg, hz_reg, wr_reg,
                             avg_acc_reg[ACC_W-1:8], smooth_acc_reg[ACC_W-1:8]};
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    a_no_hz_without_write: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[24]) |-> (m_axis_tdata[40:25] == 16'd0))
        else $error("tone frequency without tone write");

    a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");
`endif

endmodule
`default_nettype wire
